### src/wbn_pkg.sv
package wbn_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int SCORE_BITS     = 16;
    localparam int THR_BITS       = 16;

    // about 0.3 in unsigned Q0.16
    localparam logic [THR_BITS-1:0] IOU_THR_RESET = 16'd19661;

endpackage

### src/weighted_box_nms_unit.sv
// load: one box beat per cycle until the beat marked tlast
// suppression per group: 2 cycles per stored box for the top search, then 2 to 13 cycles
// per stored box in the overlap sweep (one shared multiplier, up to 8 products per box),
// then 4 divisions of (COORD_BITS+20+log2(MAX_BOXES)+3) cycles each in the serial divider
// one merged box leaves per group; no new box is taken until the last result is registered
// reset (rst_n, asynchronous): set empty, threshold back to 0.3, box store not cleared
module weighted_box_nms_unit #(
    parameter int MAX_BOXES  = wbn_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = wbn_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    // box beats in
    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, box_width, box_height, box_score, zero fill
    input  logic [((4*COORD_BITS+wbn_pkg::SCORE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,                                 // last_box

    // merged box beats out
    output logic m_tvalid,
    input  logic m_tready,
    // out_center_x, out_center_y, out_width, out_height, out_score, zero fill
    output logic [((4*COORD_BITS+wbn_pkg::SCORE_BITS+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,                                 // last_result
    output logic m_tuser,                                 // overflow

    // iou threshold write
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [wbn_pkg::THR_BITS-1:0] cfg_data
);

    import wbn_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int BOXW  = 4*C + SCORE_BITS;
    localparam int DATW  = ((BOXW + 7) / 8) * 8;
    localparam int LOGB  = $clog2(MAX_BOXES);
    localparam int CNTW  = $clog2(MAX_BOXES + 1);
    localparam int CB    = C + 2;                       // corner width, signed
    localparam int AW    = C + 3;                       // multiplier a side, signed
    localparam int BW    = (C + 1 > SCORE_BITS) ? C + 1 : SCORE_BITS;
    localparam int PW    = AW + BW + 1;
    localparam int AREAW = 2*C;
    localparam int INTW  = 2*C + 2;
    localparam int UW    = 2*C + 3;
    localparam int LSPL  = C + 2;                       // split point of the union
    localparam int CW    = 2*C + 19;
    localparam int TW    = SCORE_BITS + LOGB;
    localparam int SW    = C + 20 + LOGB;
    localparam int DVW   = TW + 2;

    localparam logic signed [SW:0] SMAX_Q = (SW+1)'((64'sd1 <<< (C-1)) - 64'sd1);
    localparam logic signed [SW:0] SMIN_Q = -SMAX_Q - (SW+1)'(1);
    localparam logic signed [SW:0] UMAX_Q = (SW+1)'((64'sd1 <<< C) - 64'sd1);

    typedef enum logic [22:0] {
        ST_LOAD      = 23'd1 << 0,
        ST_SCAN_RD   = 23'd1 << 1,
        ST_SCAN_CMP  = 23'd1 << 2,
        ST_TOP       = 23'd1 << 3,
        ST_TOPAREA   = 23'd1 << 4,
        ST_SW_RD     = 23'd1 << 5,
        ST_SW_CHK    = 23'd1 << 6,
        ST_M_INTER   = 23'd1 << 7,
        ST_M_AREA    = 23'd1 << 8,
        ST_UNI       = 23'd1 << 9,
        ST_M_ULO     = 23'd1 << 10,
        ST_M_UHI     = 23'd1 << 11,
        ST_CMP       = 23'd1 << 12,
        ST_M_X0      = 23'd1 << 13,
        ST_M_X1      = 23'd1 << 14,
        ST_M_Y0      = 23'd1 << 15,
        ST_M_Y1      = 23'd1 << 16,
        ST_ACC       = 23'd1 << 17,
        ST_GROUP_END = 23'd1 << 18,
        ST_DIV_SETUP = 23'd1 << 19,
        ST_DIV_RUN   = 23'd1 << 20,
        ST_DIV_STORE = 23'd1 << 21,
        ST_EMIT      = 23'd1 << 22
    } state_t;

    typedef enum logic [1:0] {
        JOB_CX = 2'd0,
        JOB_CY = 2'd1,
        JOB_W  = 2'd2,
        JOB_H  = 2'd3
    } job_t;

    // control state
    state_t                  state_reg,   state_next;
    logic [LOGB-1:0]         idx_reg,     idx_next;
    logic [CNTW-1:0]         count_reg,   count_next;
    logic [MAX_BOXES-1:0]    live_reg,    live_next;
    logic                    dropped_reg, dropped_next;
    logic                    found_reg,   found_next;
    logic                    merge_reg,   merge_next;
    logic                    end_reg,     end_next;
    job_t                    job_reg,     job_next;
    logic [THR_BITS-1:0]     thr_reg,     thr_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // payload
    logic [LOGB-1:0]         top_idx_reg,  top_idx_next;
    logic [BOXW-1:0]         top_word_reg, top_word_next;
    logic signed [CB-1:0]    tx0_reg, tx0_next, tx1_reg, tx1_next;
    logic signed [CB-1:0]    ty0_reg, ty0_next, ty1_reg, ty1_next;
    logic [AREAW-1:0]        at_reg,    at_next;
    logic [C:0]              iw_reg,    iw_next, ih_reg, ih_next;
    logic [INTW-1:0]         inter_reg, inter_next;
    logic [UW-1:0]           uni_reg,   uni_next;
    logic [CW-1:0]           rhs_reg,   rhs_next;
    logic signed [SW-1:0]    sx0_reg, sx0_next, sx1_reg, sx1_next;
    logic signed [SW-1:0]    sy0_reg, sy0_next, sy1_reg, sy1_next;
    logic [TW-1:0]           tot_reg,   tot_next;
    logic                    neg_reg,   neg_next;
    logic [C-1:0]            res_cx_reg, res_cx_next, res_cy_reg, res_cy_next;
    logic [C-1:0]            res_w_reg,  res_w_next,  res_h_reg,  res_h_next;
    logic [SCORE_BITS-1:0]   res_s_reg,  res_s_next;
    logic                    res_last_reg, res_last_next;
    logic [DATW-1:0]         m_tdata_reg,  m_tdata_next;
    logic                    m_tlast_reg,  m_tlast_next;
    logic                    m_tuser_reg,  m_tuser_next;

    // shared multiplier
    logic signed [AW-1:0]    mul_a;
    logic [BW-1:0]           mul_b;
    logic signed [PW-1:0]    prod_reg;

    // box store
    logic                    ram_we;
    logic [BOXW-1:0]         ram_rdata;

    // serial divider
    logic                    div_start;
    logic [SW-1:0]           div_dividend;
    logic [DVW-1:0]          div_divisor;
    logic                    div_done;
    logic [SW-1:0]           div_quo;

    // fields of the box being read
    logic signed [C-1:0]     rd_cx, rd_cy;
    logic [C-1:0]            rd_w, rd_h;
    logic [SCORE_BITS-1:0]   rd_s;
    logic signed [CB-1:0]    b_x0, b_x1, b_y0, b_y1;
    logic signed [CB-1:0]    ix0, ix1, iy0, iy1;
    logic signed [CB:0]      iw_full, ih_full;
    logic                    overlap;

    logic [C-1:0]            top_w, top_h;
    logic [SCORE_BITS-1:0]   top_s;
    logic                    s_beat;
    logic                    m_free;
    logic [LOGB-1:0]         last_idx;
    logic                    at_last_idx;
    logic [CW-1:0]           lhs_cmp, rhs_cmp;
    logic signed [SW-1:0]    tot_s, num, dsgn;
    logic signed [SW:0]      q_s;
    logic [C-1:0]            q_sat_s, q_sat_u;
    logic [MAX_BOXES-1:0]    live_wo_top;

    assign s_beat   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign m_free   = !m_tvalid_reg || m_tready;
    assign last_idx = LOGB'(count_reg - CNTW'(1));
    assign at_last_idx = (idx_reg == last_idx);
    assign ram_we   = s_beat && (count_reg < CNTW'(MAX_BOXES));

    wbn_ram #(
        .WIDTH (BOXW),
        .DEPTH (MAX_BOXES)
    ) u_box_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[LOGB-1:0]),
        .wdata (s_tdata[BOXW-1:0]),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // box corners in units of half a coordinate step
    always_comb
    begin
        rd_cx = $signed(ram_rdata[C-1:0]);
        rd_cy = $signed(ram_rdata[2*C-1:C]);
        rd_w  = ram_rdata[3*C-1:2*C];
        rd_h  = ram_rdata[4*C-1:3*C];
        rd_s  = ram_rdata[BOXW-1:4*C];
        b_x0  = (CB'(rd_cx) <<< 1) - $signed(CB'(rd_w));
        b_x1  = (CB'(rd_cx) <<< 1) + $signed(CB'(rd_w));
        b_y0  = (CB'(rd_cy) <<< 1) - $signed(CB'(rd_h));
        b_y1  = (CB'(rd_cy) <<< 1) + $signed(CB'(rd_h));
        ix0   = (b_x0 > tx0_reg) ? b_x0 : tx0_reg;
        ix1   = (b_x1 < tx1_reg) ? b_x1 : tx1_reg;
        iy0   = (b_y0 > ty0_reg) ? b_y0 : ty0_reg;
        iy1   = (b_y1 < ty1_reg) ? b_y1 : ty1_reg;
        iw_full = (CB+1)'(ix1) - (CB+1)'(ix0);
        ih_full = (CB+1)'(iy1) - (CB+1)'(iy0);
        overlap = (iw_full > 0) && (ih_full > 0);
        top_w = top_word_reg[3*C-1:2*C];
        top_h = top_word_reg[4*C-1:3*C];
        top_s = top_word_reg[BOXW-1:4*C];
    end

    // operand selection of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_TOP:
            begin
                mul_a = $signed(AW'(top_w));
                mul_b = BW'(top_h);
            end
            ST_M_INTER:
            begin
                mul_a = $signed(AW'(iw_reg));
                mul_b = BW'(ih_reg);
            end
            ST_M_AREA:
            begin
                mul_a = $signed(AW'(rd_w));
                mul_b = BW'(rd_h);
            end
            ST_M_ULO:
            begin
                mul_a = $signed(AW'(uni_reg[LSPL-1:0]));
                mul_b = BW'(thr_reg);
            end
            ST_M_UHI:
            begin
                mul_a = $signed(AW'(uni_reg[UW-1:LSPL]));
                mul_b = BW'(thr_reg);
            end
            ST_M_X0:
            begin
                mul_a = AW'(b_x0);
                mul_b = BW'(rd_s);
            end
            ST_M_X1:
            begin
                mul_a = AW'(b_x1);
                mul_b = BW'(rd_s);
            end
            ST_M_Y0:
            begin
                mul_a = AW'(b_y0);
                mul_b = BW'(rd_s);
            end
            ST_M_Y1:
            begin
                mul_a = AW'(b_y1);
                mul_b = BW'(rd_s);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a * $signed({1'b0, mul_b}));
    end

    // iou test: inter * 2^16 > union * threshold
    always_comb
    begin
        lhs_cmp = CW'({inter_reg, 16'b0});
        rhs_cmp = rhs_reg + (CW'(prod_reg[C+16:0]) << LSPL);
    end

    // rounded quotient operands: centre (n + 2t) / 4t, size (n + t) / 2t
    always_comb
    begin
        tot_s = $signed(SW'(tot_reg));
        case (job_reg)
            JOB_CX:  num = sx0_reg + sx1_reg + (tot_s <<< 1);
            JOB_CY:  num = sy0_reg + sy1_reg + (tot_s <<< 1);
            JOB_W:   num = sx1_reg - sx0_reg + tot_s;
            JOB_H:   num = sy1_reg - sy0_reg + tot_s;
            default: num = '0;
        endcase
        if (job_reg == JOB_CX || job_reg == JOB_CY)
        begin
            div_divisor = {tot_reg, 2'b00};
        end
        else
        begin
            div_divisor = DVW'({tot_reg, 1'b0});
        end
        dsgn = $signed(SW'(div_divisor));
        // floor division of a negative value through its ceiling magnitude
        div_dividend = (num < 0) ? SW'(dsgn - SW'(1) - num) : SW'(num);
        div_start    = (state_reg == ST_DIV_SETUP);
    end

    wbn_div #(
        .NW (SW),
        .DW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // signed quotient and its two saturations
    always_comb
    begin
        q_s = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        if (q_s > SMAX_Q)
        begin
            q_sat_s = SMAX_Q[C-1:0];
        end
        else if (q_s < SMIN_Q)
        begin
            q_sat_s = SMIN_Q[C-1:0];
        end
        else
        begin
            q_sat_s = q_s[C-1:0];
        end
        if (q_s < 0)
        begin
            q_sat_u = '0;
        end
        else if (q_s > UMAX_Q)
        begin
            q_sat_u = UMAX_Q[C-1:0];
        end
        else
        begin
            q_sat_u = q_s[C-1:0];
        end
        live_wo_top = live_reg & ~(MAX_BOXES'(1) << top_idx_reg);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        live_next     = live_reg;
        dropped_next  = dropped_reg;
        found_next    = found_reg;
        merge_next    = merge_reg;
        end_next      = end_reg;
        job_next      = job_reg;
        thr_next      = thr_reg;
        m_tvalid_next = m_tvalid_reg;
        top_idx_next  = top_idx_reg;
        top_word_next = top_word_reg;
        tx0_next = tx0_reg;
        tx1_next = tx1_reg;
        ty0_next = ty0_reg;
        ty1_next = ty1_reg;
        at_next    = at_reg;
        iw_next    = iw_reg;
        ih_next    = ih_reg;
        inter_next = inter_reg;
        uni_next   = uni_reg;
        rhs_next   = rhs_reg;
        sx0_next = sx0_reg;
        sx1_next = sx1_reg;
        sy0_next = sy0_reg;
        sy1_next = sy1_reg;
        tot_next = tot_reg;
        neg_next = neg_reg;
        res_cx_next   = res_cx_reg;
        res_cy_next   = res_cy_reg;
        res_w_next    = res_w_reg;
        res_h_next    = res_h_reg;
        res_s_next    = res_s_reg;
        res_last_next = res_last_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (s_beat)
                begin
                    if (ram_we)
                    begin
                        live_next[count_reg[LOGB-1:0]] = 1'b1;
                        count_next = count_reg + CNTW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                // strict compare keeps the earliest box on a tie
                if (live_reg[idx_reg] && (!found_reg || rd_s > top_s))
                begin
                    found_next    = 1'b1;
                    top_idx_next  = idx_reg;
                    top_word_next = ram_rdata;
                    tx0_next = b_x0;
                    tx1_next = b_x1;
                    ty0_next = b_y0;
                    ty1_next = b_y1;
                end
                if (at_last_idx)
                begin
                    state_next = ST_TOP;
                end
                else
                begin
                    idx_next   = idx_reg + LOGB'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_TOP:
            begin
                if (top_w == '0 || top_h == '0)
                begin
                    // degenerate top box ends the set as it stands
                    res_cx_next   = top_word_reg[C-1:0];
                    res_cy_next   = top_word_reg[2*C-1:C];
                    res_w_next    = top_w;
                    res_h_next    = top_h;
                    res_s_next    = top_s;
                    res_last_next = 1'b1;
                    end_next      = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_TOPAREA;
                end
            end
            ST_TOPAREA:
            begin
                at_next  = prod_reg[AREAW-1:0];
                sx0_next = '0;
                sx1_next = '0;
                sy0_next = '0;
                sy1_next = '0;
                tot_next = '0;
                idx_next = '0;
                state_next = ST_SW_RD;
            end
            ST_SW_RD:
            begin
                state_next = ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                if (live_reg[idx_reg] && overlap)
                begin
                    iw_next    = iw_full[C:0];
                    ih_next    = ih_full[C:0];
                    state_next = ST_M_INTER;
                end
                else if (at_last_idx)
                begin
                    state_next = ST_GROUP_END;
                end
                else
                begin
                    idx_next   = idx_reg + LOGB'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_M_INTER:
            begin
                state_next = ST_M_AREA;
            end
            ST_M_AREA:
            begin
                inter_next = prod_reg[INTW-1:0];
                state_next = ST_UNI;
            end
            ST_UNI:
            begin
                uni_next = UW'({at_reg, 2'b00}) + UW'({prod_reg[AREAW-1:0], 2'b00})
                         - UW'(inter_reg);
                state_next = ST_M_ULO;
            end
            ST_M_ULO:
            begin
                state_next = ST_M_UHI;
            end
            ST_M_UHI:
            begin
                rhs_next   = CW'(prod_reg[C+17:0]);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                merge_next = (uni_reg != '0) && (lhs_cmp > rhs_cmp);
                if ((uni_reg != '0) && (lhs_cmp > rhs_cmp))
                begin
                    state_next = ST_M_X0;
                end
                else if (at_last_idx)
                begin
                    state_next = ST_GROUP_END;
                end
                else
                begin
                    idx_next   = idx_reg + LOGB'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_M_X0:
            begin
                state_next = ST_M_X1;
            end
            ST_M_X1:
            begin
                sx0_next   = sx0_reg + SW'($signed(prod_reg[C+17:0]));
                state_next = ST_M_Y0;
            end
            ST_M_Y0:
            begin
                sx1_next   = sx1_reg + SW'($signed(prod_reg[C+17:0]));
                state_next = ST_M_Y1;
            end
            ST_M_Y1:
            begin
                sy0_next   = sy0_reg + SW'($signed(prod_reg[C+17:0]));
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sy1_next = sy1_reg + SW'($signed(prod_reg[C+17:0]));
                tot_next = tot_reg + TW'(rd_s);
                live_next[idx_reg] = 1'b0;
                if (at_last_idx)
                begin
                    state_next = ST_GROUP_END;
                end
                else
                begin
                    idx_next   = idx_reg + LOGB'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_GROUP_END:
            begin
                live_next     = live_wo_top;
                res_s_next    = top_s;
                res_last_next = (live_wo_top == '0);
                end_next      = (live_wo_top == '0);
                if (tot_reg == '0)
                begin
                    res_cx_next = top_word_reg[C-1:0];
                    res_cy_next = top_word_reg[2*C-1:C];
                    res_w_next  = top_w;
                    res_h_next  = top_h;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    job_next   = JOB_CX;
                    state_next = ST_DIV_SETUP;
                end
            end
            ST_DIV_SETUP:
            begin
                neg_next   = (num < 0);
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE:
            begin
                case (job_reg)
                    JOB_CX:  res_cx_next = q_sat_s;
                    JOB_CY:  res_cy_next = q_sat_s;
                    JOB_W:   res_w_next  = q_sat_u;
                    JOB_H:   res_h_next  = q_sat_u;
                    default: res_h_next  = q_sat_u;
                endcase
                if (job_reg == JOB_H)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    job_next   = job_t'(job_reg + 2'd1);
                    state_next = ST_DIV_SETUP;
                end
            end
            ST_EMIT:
            begin
                if (m_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = DATW'({res_s_reg, res_h_reg, res_w_reg,
                                           res_cy_reg, res_cx_reg});
                    m_tlast_next  = res_last_reg;
                    m_tuser_next  = dropped_reg;
                    if (end_reg)
                    begin
                        live_next    = '0;
                        count_next   = '0;
                        dropped_next = 1'b0;
                        end_next     = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            idx_reg      <= '0;
            count_reg    <= '0;
            live_reg     <= '0;
            dropped_reg  <= 1'b0;
            found_reg    <= 1'b0;
            merge_reg    <= 1'b0;
            end_reg      <= 1'b0;
            job_reg      <= JOB_CX;
            thr_reg      <= IOU_THR_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            live_reg     <= live_next;
            dropped_reg  <= dropped_next;
            found_reg    <= found_next;
            merge_reg    <= merge_next;
            end_reg      <= end_next;
            job_reg      <= job_next;
            thr_reg      <= thr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_idx_reg  <= top_idx_next;
        top_word_reg <= top_word_next;
        tx0_reg <= tx0_next;
        tx1_reg <= tx1_next;
        ty0_reg <= ty0_next;
        ty1_reg <= ty1_next;
        at_reg    <= at_next;
        iw_reg    <= iw_next;
        ih_reg    <= ih_next;
        inter_reg <= inter_next;
        uni_reg   <= uni_next;
        rhs_reg   <= rhs_next;
        sx0_reg <= sx0_next;
        sx1_reg <= sx1_next;
        sy0_reg <= sy0_next;
        sy1_reg <= sy1_next;
        tot_reg <= tot_next;
        neg_reg <= neg_next;
        res_cx_reg   <= res_cx_next;
        res_cy_reg   <= res_cy_next;
        res_w_reg    <= res_w_next;
        res_h_reg    <= res_h_next;
        res_s_reg    <= res_s_next;
        res_last_reg <= res_last_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // a merge decision is only ever followed by the weighted sums
    a_merge_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && uni_reg != '0 && lhs_cmp > rhs_cmp) |=> state_reg == ST_M_X0)
        else $error("merge decision not followed by accumulation");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> count_reg == CNTW'(MAX_BOXES))
        else $error("box dropped while store not full");

    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("box taken after end of set");

    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg >> count_reg) == '0)
        else $error("live box beyond loaded count");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_RUN)
        else $error("divider finished outside its wait state");

endmodule

### src/wbn_ram.sv
module wbn_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/wbn_div.sv
module wbn_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   dvs_reg;

    logic [DW:0]     rem_sh;
    logic            ge;
    logic [DW:0]     rem_sub;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NW-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBOX = wbn_pkg::MAX_BOXES_DEF;
    localparam int CW   = wbn_pkg::COORD_BITS_DEF;
    localparam int DW   = ((4*CW+wbn_pkg::SCORE_BITS+7)/8)*8;
    // worst group: top search, full overlap sweep and four serial divisions
    localparam int STALL_LIMIT = 40000;
    // quiet cycles after the last merged box before a threshold write
    localparam int SETTLE = 40;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [CW-1:0]        w;
        logic [CW-1:0]        h;
        logic [15:0]          score;
    } box_t;

    typedef struct packed {
        box_t b;
        logic last;
        logic ovf;
    } merged_t;

    // directed row: typed rows are single-box sets whose answer is obvious
    typedef struct {
        box_t b;
        logic last;
        logic typed;
        box_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [wbn_pkg::THR_BITS-1:0] cfg_data = '0;

    always #4 clk = ~clk;

    weighted_box_nms_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // predictor copy of the block's state
    logic [15:0] thr_q = wbn_pkg::IOU_THR_RESET;
    box_t        set_q[$];      // boxes loaded in the open set
    int          set_seen = 0;  // beats in the open set, dropped ones included
    merged_t     merged_q[$];   // merged boxes still to arrive

    int errors = 0;
    int n_beats = 0;
    int n_sets = 0;
    int n_merged = 0;
    int n_ovf = 0;
    int snd_idle = 0;
    int rcv_idle = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on merged box %0d: %s got %0d want %0d", n_merged, what, got, want);
        errors++;
    endtask

    function automatic longint fdiv(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint rdiv(input longint n, input longint d);
        return fdiv(2*n + d, 2*d);
    endfunction

    function automatic longint sat_s(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint sat_u(input longint v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    // exact iou test against the threshold, inter/union > thr/65536
    function automatic bit merges(input box_t a, input box_t t);
        longint ax0, ax1, ay0, ay1, tx0, tx1, ty0, ty1, ix0, ix1, iy0, iy1, inter, uni;
        ax0 = 2*longint'(a.cx) - longint'(a.w);
        ax1 = 2*longint'(a.cx) + longint'(a.w);
        ay0 = 2*longint'(a.cy) - longint'(a.h);
        ay1 = 2*longint'(a.cy) + longint'(a.h);
        tx0 = 2*longint'(t.cx) - longint'(t.w);
        tx1 = 2*longint'(t.cx) + longint'(t.w);
        ty0 = 2*longint'(t.cy) - longint'(t.h);
        ty1 = 2*longint'(t.cy) + longint'(t.h);
        ix0 = (ax0 > tx0) ? ax0 : tx0;
        ix1 = (ax1 < tx1) ? ax1 : tx1;
        iy0 = (ay0 > ty0) ? ay0 : ty0;
        iy1 = (ay1 < ty1) ? ay1 : ty1;
        if (ix0 >= ix1 || iy0 >= iy1)
            return 1'b0;
        inter = (ix1 - ix0) * (iy1 - iy0);
        uni = 4*longint'(a.w)*longint'(a.h) + 4*longint'(t.w)*longint'(t.h) - inter;
        if (uni == 0)
            return 1'b0;
        return (inter * 65536) > (uni * longint'(thr_q));
    endfunction

    // suppression over the closed set, queues the merged boxes
    task automatic suppress_set();
        bit      live[NBOX];
        int      top, k, made;
        longint  sx0, sx1, sy0, sy1, tot, s;
        box_t    t, b;
        merged_t r;
        bit      ovf;
        ovf = (set_seen > NBOX);
        for (k = 0; k < NBOX; k++)
            live[k] = (k < set_q.size());
        made = 0;
        forever
        begin
            top = -1;
            for (k = 0; k < set_q.size(); k++)
                if (live[k] && (top < 0 || set_q[k].score > set_q[top].score))
                    top = k;
            if (top < 0)
                break;
            t = set_q[top];
            r.last = 1'b0;
            r.ovf = ovf;
            r.b = t;
            made++;
            if (t.w == 0 || t.h == 0)
            begin
                // zero-area top ends the set
                merged_q = {merged_q, r};
                break;
            end
            sx0 = 0; sx1 = 0; sy0 = 0; sy1 = 0; tot = 0;
            for (k = 0; k < set_q.size(); k++)
            begin
                b = set_q[k];
                if (!live[k] || !merges(b, t))
                    continue;
                s = longint'(b.score);
                tot += s;
                sx0 += (2*longint'(b.cx) - longint'(b.w)) * s;
                sx1 += (2*longint'(b.cx) + longint'(b.w)) * s;
                sy0 += (2*longint'(b.cy) - longint'(b.h)) * s;
                sy1 += (2*longint'(b.cy) + longint'(b.h)) * s;
                live[k] = 1'b0;
            end
            live[top] = 1'b0;
            if (tot != 0)
            begin
                r.b.cx = CW'(sat_s(rdiv(sx0 + sx1, 4*tot)));
                r.b.cy = CW'(sat_s(rdiv(sy0 + sy1, 4*tot)));
                r.b.w  = CW'(sat_u(rdiv(sx1 - sx0, 2*tot)));
                r.b.h  = CW'(sat_u(rdiv(sy1 - sy0, 2*tot)));
            end
            merged_q = {merged_q, r};
        end
        if (made > 0)
            merged_q[merged_q.size()-1].last = 1'b1;
        set_q.delete();
        set_seen = 0;
        n_sets++;
    endtask

    // one box beat; typed rows bypass the predictor
    task automatic send_box(input box_t b, input logic last, input logic typed, input box_t want);
        merged_t r;
        if ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.score, b.h, b.w, b.cy, b.cx};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        n_beats++;
        if (typed)
        begin
            r.b = want;
            r.last = 1'b1;
            r.ovf = 1'b0;
            merged_q = {merged_q, r};
            set_q.delete();
            set_seen = 0;
            n_sets++;
        end
        else
        begin
            if (set_q.size() < NBOX)
                set_q = {set_q, b};
            set_seen++;
            if (last)
                suppress_set();
        end
    endtask

    // wait until every merged box has arrived, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (merged_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_thr(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_q = v;
    endtask

    function automatic box_t rand_box();
        box_t b;
        b.cx = CW'($urandom);
        b.cy = CW'($urandom);
        b.w = CW'($urandom);
        b.h = CW'($urandom);
        b.score = 16'($urandom);
        return b;
    endfunction

    // one random set: mostly a few clusters of overlapping boxes, some noise
    task automatic random_set(input int n);
        box_t b, base, none;
        int   k, pick;
        none = '0;
        base = rand_box();
        base.cx = CW'($signed(16'($urandom_range(0, 24000))) - 12000);
        base.cy = CW'($signed(16'($urandom_range(0, 24000))) - 12000);
        base.w = CW'($urandom_range(200, 6000));
        base.h = CW'($urandom_range(200, 6000));
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                b = rand_box();
            else
            begin
                if ($urandom_range(3) == 0)
                begin
                    base.cx = CW'($signed(16'($urandom_range(0, 24000))) - 12000);
                    base.cy = CW'($signed(16'($urandom_range(0, 24000))) - 12000);
                end
                b.cx = CW'(base.cx + $signed(16'($urandom_range(0, 800))) - 400);
                b.cy = CW'(base.cy + $signed(16'($urandom_range(0, 800))) - 400);
                b.w = CW'(base.w + $urandom_range(0, 600));
                b.h = CW'(base.h + $urandom_range(0, 600));
                b.score = 16'($urandom);
            end
            if (pick >= 12 && pick < 16)
                b.score = '0;
            if (pick >= 16 && pick < 19)
                b.score = 16'hc000;                   // ties
            if (pick == 19)
                b.w = '0;                             // zero area
            if (pick == 20)
                b.h = '0;
            send_box(b, (k == n-1), 1'b0, none);
        end
    endtask

    task automatic random_phase(input int beats);
        int sent, n;
        sent = 0;
        while (sent < beats)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            random_set(n);
            sent += n;
        end
    endtask

    // receiver side stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle);

    // merged box checker
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            merged_t w;
            box_t    g;
            g.cx    = m_tdata[CW-1:0];
            g.cy    = m_tdata[2*CW-1:CW];
            g.w     = m_tdata[3*CW-1:2*CW];
            g.h     = m_tdata[4*CW-1:3*CW];
            g.score = m_tdata[4*CW+15:4*CW];
            if (merged_q.size() == 0)
            begin
                report("unexpected merged box", 1, 0);
            end
            else
            begin
                w = merged_q.pop_front();
                if (g.cx !== w.b.cx) report("center_x", g.cx, w.b.cx);
                if (g.cy !== w.b.cy) report("center_y", g.cy, w.b.cy);
                if (g.w !== w.b.w) report("width", g.w, w.b.w);
                if (g.h !== w.b.h) report("height", g.h, w.b.h);
                if (g.score !== w.b.score) report("score", g.score, w.b.score);
                if (m_tlast !== w.last) report("last", m_tlast, w.last);
                if (m_tuser !== w.ovf) report("overflow", m_tuser, w.ovf);
            end
            n_merged++;
            if (m_tuser === 1'b1)
                n_ovf++;
        end
    end

    // watchdog on cycles with no beat on any channel
    int quiet = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT)
        begin
            $display("timeout, %0d merged boxes outstanding", merged_q.size());
            $display("status: fail");
            $finish;
        end
    end

    row_t rows[$];

    function automatic row_t mk(input int cx, input int cy, input int w, input int h,
                                input int sc, input logic last, input logic typed);
        row_t r;
        r.b.cx = CW'(cx);
        r.b.cy = CW'(cy);
        r.b.w = CW'(w);
        r.b.h = CW'(h);
        r.b.score = 16'(sc);
        r.last = last;
        r.typed = typed;
        r.want = r.b;
        return r;
    endfunction

    initial
    begin
        box_t none, b;
        int k;
        none = '0;

        // single-box sets come back unchanged
        rows = {rows, mk(32767, 32767, 65535, 65535, 65535, 1, 1)};
        rows = {rows, mk(-32768, -32768, 1, 1, 1, 1, 1)};
        rows = {rows, mk(100, -200, 0, 500, 500, 1, 1)};       // zero width
        rows = {rows, mk(-300, 400, 700, 0, 900, 1, 1)};       // zero height
        rows = {rows, mk(0, 0, 4000, 4000, 0, 1, 1)};          // zero score sum
        // two overlapping boxes merge
        rows = {rows, mk(1000, 1000, 4000, 4000, 30000, 0, 0)};
        rows = {rows, mk(1200, 900, 4200, 3800, 50000, 1, 0)};
        // equal scores, earliest wins; a disjoint box stays on its own
        rows = {rows, mk(-5000, 2000, 3000, 3000, 40000, 0, 0)};
        rows = {rows, mk(-4900, 2100, 3000, 3000, 40000, 0, 0)};
        rows = {rows, mk(9000, -9000, 2000, 2000, 40000, 1, 0)};
        // zero-area top discards the rest
        rows = {rows, mk(0, 0, 3000, 3000, 100, 0, 0)};
        rows = {rows, mk(50, 50, 0, 3000, 60000, 0, 0)};
        rows = {rows, mk(9000, 9000, 3000, 3000, 200, 1, 0)};
        // group whose scores are all zero
        rows = {rows, mk(2000, 2000, 3000, 3000, 0, 0, 0)};
        rows = {rows, mk(2100, 2000, 3000, 3000, 0, 1, 0)};
        // huge boxes at the corners, saturation of the merged result
        rows = {rows, mk(32767, -32768, 65535, 65535, 65535, 0, 0)};
        rows = {rows, mk(32000, -32000, 65535, 65535, 65535, 1, 0)};

        snd_idle = 17;
        rcv_idle = 47;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part at the reset threshold
        foreach (rows[i])
            send_box(rows[i].b, rows[i].last, rows[i].typed, rows[i].want);
        drain();

        write_thr(16'd0);
        random_phase(45);
        // overfull set: boxes past capacity are dropped and flagged
        for (k = 0; k < NBOX + 6; k++)
        begin
            b = rand_box();
            b.w = CW'($urandom_range(1, 3000));
            b.h = CW'($urandom_range(1, 3000));
            send_box(b, (k == NBOX + 5), 1'b0, none);
        end
        drain();

        snd_idle = 47;
        rcv_idle = 17;
        write_thr(16'hffff);
        random_phase(45);
        drain();
        write_thr(16'($urandom));
        random_phase(45);
        drain();

        snd_idle = 0;
        rcv_idle = 0;
        write_thr(wbn_pkg::IOU_THR_RESET);
        random_phase(40);
        drain();

        $display("covered %0d box beats in %0d sets, %0d merged boxes, %0d flagged overflow",
                 n_beats, n_sets, n_merged, n_ovf);
        $display("thresholds zero, full scale, random and default; %0d mismatches", errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
